[rtl/sha1s_pkg.sv]
// sha1s_pkg: shared types and constants of the sha-1 stream hasher
// used by sha1s_core and sha1_stream_hasher; no dependencies
`default_nettype none

package sha1s_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumH      = 5;
  localparam int unsigned Rounds    = 80;
  localparam int unsigned RoundW    = $clog2(Rounds);
  localparam int unsigned BlockW    = 16;
  localparam int unsigned CountW    = $clog2(BlockW);

  // initial chaining words
  localparam logic [NumH-1:0][WordW-1:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // round constants, one per group of twenty rounds
  localparam logic [WordW-1:0] K_0 = 32'h5A827999;
  localparam logic [WordW-1:0] K_1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K_2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K_3 = 32'hCA62C1D6;

  // padding word that follows a full final word
  localparam logic [WordW-1:0] PAD_WORD = 32'h80000000;
  localparam logic [7:0]       PAD_BYTE = 8'h80;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic              push;    // shift a message word into the schedule
    logic              start;   // load working vars from chaining words
    logic              round;   // run one round
    logic              finish;  // fold working vars into chaining words
    logic              init;    // restore initial chaining words
    logic [RoundW-1:0] rnd;     // current round number
  } sha1s_ctrl_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PAD    = 5'b00010,
    ST_ROUND  = 5'b00100,
    ST_FINISH = 5'b01000,
    ST_OUT    = 5'b10000
  } sha1s_state_e;

endpackage

`default_nettype wire

[rtl/sha1s_core.sv]
// sha1s_core: message schedule shift line, working variables, one shared
// round adder and the chaining words; depends on sha1s_pkg
`default_nettype none

module sha1s_core
  import sha1s_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire sha1s_ctrl_t                ctrl_i,
  input  wire logic [WordW-1:0]           word_i,
  output logic      [NumH-1:0][WordW-1:0] h_o
);

  logic [BlockW-1:0][WordW-1:0] w_q;
  logic [WordW-1:0] a_q, b_q, c_q, d_q, e_q;
  logic [NumH-1:0][WordW-1:0] h_q;

  logic [WordW-1:0] w_mix;
  logic [WordW-1:0] w_next;
  logic [WordW-1:0] f_val;
  logic [WordW-1:0] k_val;
  logic [WordW-1:0] t_val;

  // next schedule word from fixed taps of the shift line
  always_comb begin
    w_mix  = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_next = {w_mix[WordW-2:0], w_mix[WordW-1]};
  end

  // round function and constant by group of twenty rounds
  always_comb begin
    if (ctrl_i.rnd < RoundW'(20)) begin
      f_val = (b_q & c_q) ^ (~b_q & d_q);
      k_val = K_0;
    end else if (ctrl_i.rnd < RoundW'(40)) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K_1;
    end else if (ctrl_i.rnd < RoundW'(60)) begin
      f_val = (b_q & c_q) ^ (b_q & d_q) ^ (c_q & d_q);
      k_val = K_2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K_3;
    end
  end

  // shared round adder
  assign t_val = {a_q[WordW-6:0], a_q[WordW-1:WordW-5]} + f_val + e_q + k_val + w_q[0];

  // schedule shift line, oldest word at index zero
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      w_q <= {word_i, w_q[BlockW-1:1]};
    end else if (ctrl_i.round) begin
      w_q <= {w_next, w_q[BlockW-1:1]};
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (ctrl_i.round) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[WordW-1:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  // chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= H_INIT;
    end else if (ctrl_i.init) begin
      h_q <= H_INIT;
    end else if (ctrl_i.finish) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
      h_q[4] <= h_q[4] + e_q;
    end
  end

  assign h_o = h_q;

endmodule

`default_nettype wire

[rtl/sha1_stream_hasher.sv]
// sha1_stream_hasher: sha-1 over a stream of big-endian words; uses sha1s_core, sha1s_pkg
// a word that does not fill the block leaves the hasher ready for the next word; the word that fills it
// starts 80 rounds in the shared round adder, then the chaining add
// a last word adds padding and length words and one or two compressions,
// then five digest items, one per cycle as taken; no input is taken meanwhile
// async active-low reset restores chaining words, clears count and length, not the buffer
`default_nettype none

module sha1_stream_hasher
  import sha1s_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WordW-1:0] data_word_i,
  input  wire logic [2:0]       valid_bytes_i,
  input  wire logic             last_i,
  input  wire logic             empty_message_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [WordW-1:0] digest_word_o,
  output logic      [2:0]       word_index_o,
  output logic                  digest_last_o
);

  sha1s_state_e state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [63:0]       bits_q, bits_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic [2:0]        idx_q, idx_d;
  logic              pad_q, pad_d;      // inside the padding sequence
  logic              pad80_q, pad80_d;  // padding word still owed after a full word
  logic              lo_q, lo_d;        // low length word is next
  logic              done_q, done_d;    // length pushed, digest after this block

  sha1s_ctrl_t              ctrl;
  logic [WordW-1:0]         push_word;
  logic [NumH-1:0][WordW-1:0] h_words;

  logic [2:0]       nbytes;
  logic [WordW-1:0] keep_mask;
  logic [WordW-1:0] pad_bits;
  logic [WordW-1:0] first_word;

  // effective byte count of the last word
  always_comb begin
    if (empty_message_i || (valid_bytes_i == 3'd0)) begin
      nbytes = 3'd0;
    end else if (valid_bytes_i > 3'd4) begin
      nbytes = 3'd4;
    end else begin
      nbytes = valid_bytes_i;
    end
  end

  // byte mask and padding byte placement of a partial last word
  always_comb begin
    case (nbytes[1:0])
      2'd0:    keep_mask = 32'h00000000;
      2'd1:    keep_mask = 32'hFF000000;
      2'd2:    keep_mask = 32'hFFFF0000;
      2'd3:    keep_mask = 32'hFFFFFF00;
      default: keep_mask = 32'h00000000;
    endcase
    pad_bits   = {PAD_BYTE, 24'd0} >> {nbytes[1:0], 3'b000};
    first_word = (nbytes == 3'd4) ? data_word_i : ((data_word_i & keep_mask) | pad_bits);
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    bits_d    = bits_q;
    rnd_d     = rnd_q;
    idx_d     = idx_q;
    pad_d     = pad_q;
    pad80_d   = pad80_q;
    lo_d      = lo_q;
    done_d    = done_q;
    ctrl      = '0;
    ctrl.rnd  = rnd_q;
    push_word = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl.push = 1'b1;
          count_d   = count_q + CountW'(1);
          if (last_i) begin
            push_word = first_word;
            bits_d    = bits_q + {58'd0, nbytes, 3'b000};
            pad_d     = 1'b1;
            pad80_d   = (nbytes == 3'd4);
            state_d   = ST_PAD;
          end else begin
            push_word = data_word_i;
            bits_d    = bits_q + 64'd32;
          end
          if (count_q == CountW'(BlockW - 1)) begin
            ctrl.start = 1'b1;
            rnd_d      = '0;
            state_d    = ST_ROUND;
          end
        end
      end

      ST_PAD: begin
        ctrl.push = 1'b1;
        count_d   = count_q + CountW'(1);
        if (pad80_q) begin
          push_word = PAD_WORD;
          pad80_d   = 1'b0;
        end else if (lo_q) begin
          push_word = bits_q[31:0];
          lo_d      = 1'b0;
          done_d    = 1'b1;
        end else if (count_q == CountW'(BlockW - 2)) begin
          push_word = bits_q[63:32];
          lo_d      = 1'b1;
        end else begin
          push_word = '0;
        end
        if (count_q == CountW'(BlockW - 1)) begin
          ctrl.start = 1'b1;
          rnd_d      = '0;
          state_d    = ST_ROUND;
        end
      end

      ST_ROUND: begin
        ctrl.round = 1'b1;
        if (rnd_q == RoundW'(Rounds - 1)) begin
          state_d = ST_FINISH;
        end else begin
          rnd_d = rnd_q + RoundW'(1);
        end
      end

      ST_FINISH: begin
        ctrl.finish = 1'b1;
        idx_d       = '0;
        if (done_q) begin
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (out_ready_i) begin
          if (idx_q == 3'(NumH - 1)) begin
            ctrl.init = 1'b1;
            bits_d    = '0;
            pad_d     = 1'b0;
            done_d    = 1'b0;
            state_d   = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      pad_q   <= 1'b0;
      pad80_q <= 1'b0;
      lo_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      bits_q  <= bits_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      pad_q   <= pad_d;
      pad80_q <= pad80_d;
      lo_q    <= lo_d;
      done_q  <= done_d;
    end
  end

  // round unit
  sha1s_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .word_i (push_word),
    .h_o    (h_words)
  );

  // handshake and digest output
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = h_words[idx_q];
  assign word_index_o  = idx_q;
  assign digest_last_o = (idx_q == 3'(NumH - 1));

endmodule

`default_nettype wire

[rtl/sha1s_checker.sv]
// sha1s_checker: port-level assertions for sha1_stream_hasher and its bind
// depends only on the top level's ports
`default_nettype none

module sha1s_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] digest_word_o,
  input wire logic [2:0]  word_index_o,
  input wire logic        digest_last_o
);

  // a stalled digest item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_word_o)
      && $stable(word_index_o))
    else $error("digest item changed while stalled");

  // no input taken while digest items are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready during digest output");

  // digest words come back to back in index order
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !digest_last_o |=>
      out_valid_o && (word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest index did not step");

  // last flag marks the fifth word
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digest_last_o == (word_index_o == 3'd4)))
    else $error("digest last flag mismatch");

  // after the fifth word the block is ready for a new message
  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && digest_last_o |=> in_ready_o && !out_valid_o)
    else $error("not idle after digest");

endmodule

bind sha1_stream_hasher sha1s_checker u_checker (.*);

`default_nettype wire

[sim/sha1_stream_hasher_test.sv]
// sha1_stream_hasher_test: self-checking testbench for the sha-1 stream hasher
// depends on rtl/sha1s_pkg.sv and rtl/sha1_stream_hasher.sv; predicts each digest
// with its own sha-1 model and checks every digest item against it
`timescale 1ns / 1ps

module sha1_stream_hasher_test;
  import sha1s_pkg::*;

  localparam int unsigned WordBytes   = 4;
  localparam int unsigned LenHiSlot   = 14;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned RandomItems = 250;

  // block inputs, known from time zero
  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic [WordW-1:0] data_word_i     = '0;
  logic [2:0]       valid_bytes_i   = '0;
  logic             last_i          = 1'b0;
  logic             empty_message_i = 1'b0;
  logic             out_ready_i     = 1'b0;

  // block outputs
  logic             in_ready_o;
  logic             out_valid_o;
  logic [WordW-1:0] digest_word_o;
  logic [2:0]       word_index_o;
  logic             digest_last_o;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [2:0]       index;
    logic             last;
  } digest_item_t;

  // predicted digest items, oldest first
  digest_item_t digest_q[$];

  // predictor state
  logic [WordW-1:0] chain_h[NumH];
  logic [WordW-1:0] block_w[BlockW];
  int unsigned      block_fill;
  logic [63:0]      msg_bits;

  int unsigned errors      = 0;
  int unsigned items_taken = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          send_idle   = 1'b0;
  bit          recv_idle   = 1'b0;

  sha1_stream_hasher dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor: back to the initial chaining words
  function automatic void hash_reset();
    for (int k = 0; k < NumH; k++) chain_h[k] = H_INIT[k];
    block_fill = 0;
    msg_bits   = '0;
  endfunction

  // predictor: 80 rounds over the buffered block
  function automatic void compress_block();
    logic [WordW-1:0] w[80];
    logic [WordW-1:0] a, b, c, d, e, f, t, x, kr;
    for (int i = 0; i < 16; i++) w[i] = block_w[i];
    for (int i = 16; i < 80; i++) begin
      x    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f  = (b & c) ^ (~b & d);
        kr = K_0;
      end else if (i < 40) begin
        f  = b ^ c ^ d;
        kr = K_1;
      end else if (i < 60) begin
        f  = (b & c) ^ (b & d) ^ (c & d);
        kr = K_2;
      end else begin
        f  = b ^ c ^ d;
        kr = K_3;
      end
      t = {a[26:0], a[31:27]} + f + e + kr + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // predictor: buffer one word, compress on a full block
  function automatic void absorb_word(input logic [WordW-1:0] wd);
    block_w[block_fill] = wd;
    block_fill++;
    if (block_fill == BlockW) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // predictor: one accepted item; a last word pads and yields the digest
  function automatic void predict_item(input logic [WordW-1:0] data,
                                       input logic [2:0] nbytes_in,
                                       input logic is_last, input logic no_bytes);
    int unsigned  nbytes;
    logic [WordW-1:0] keep;
    digest_item_t item;
    if (!is_last) begin
      msg_bits += 64'd32;
      absorb_word(data);
      return;
    end
    nbytes = no_bytes ? 0 : ((nbytes_in > WordBytes) ? WordBytes : nbytes_in);
    msg_bits += 64'(nbytes * 8);
    if (nbytes == WordBytes) begin
      absorb_word(data);
      absorb_word(PAD_WORD);
    end else begin
      keep = (nbytes == 0) ? '0 : ~({WordW{1'b1}} >> (8 * nbytes));
      absorb_word((data & keep) | (PAD_WORD >> (8 * nbytes)));
    end
    while (block_fill != LenHiSlot) absorb_word('0);
    absorb_word(msg_bits[63:32]);
    absorb_word(msg_bits[31:0]);
    for (int k = 0; k < NumH; k++) begin
      item.word  = chain_h[k];
      item.index = 3'(k);
      item.last  = (k == NumH - 1);
      digest_q.push_back(item);
    end
    hash_reset();
  endfunction

  // input monitor: predict every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      items_taken++;
      predict_item(data_word_i, valid_bytes_i, last_i, empty_message_i);
    end
  end

  // digest checker: compare each accepted item with the oldest prediction
  always @(posedge clk_i) begin
    digest_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest item: word %h index %0d last %0b",
               digest_word_o, word_index_o, digest_last_o);
        errors++;
      end else begin
        want = digest_q.pop_front();
        if (digest_word_o !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, digest_word_o);
          errors++;
        end
        if (word_index_o !== want.index) begin
          $error("word_index: expected %0d, got %0d", want.index, word_index_o);
          errors++;
        end
        if (digest_last_o !== want.last) begin
          $error("digest_last: expected %0b, got %0b", want.last, digest_last_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // receiver: ready drops in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // send one item, with an optional gap before it
  task automatic send_item(input logic [WordW-1:0] data, input logic [2:0] nbytes,
                           input logic is_last, input logic no_bytes);
    @(negedge clk_i);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_word_i     <= data;
    valid_bytes_i   <= nbytes;
    last_i          <= is_last;
    empty_message_i <= no_bytes;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold the input idle until every predicted digest item has come
  task automatic wait_for_digests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // message of n_words items; non-last words carry noise in the ignored fields
  task automatic send_message(input int unsigned n_words, input logic [2:0] last_nbytes,
                              input logic last_empty);
    for (int i = 1; i < n_words; i++) begin
      send_item($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'($urandom_range(0, 1)));
    end
    send_item($urandom, last_nbytes, 1'b1, last_empty);
  endtask

  // random message shape, lengths clustered around the padding boundary
  task automatic send_random_message();
    int unsigned n_words;
    int unsigned pick;
    logic [2:0]  nbytes;
    pick = $urandom_range(0, 9);
    if (pick < 6) n_words = $urandom_range(1, 18);
    else if (pick < 9) n_words = $urandom_range(12, 20);
    else n_words = $urandom_range(20, 40);
    if ($urandom_range(0, 9) == 0) nbytes = 3'($urandom_range(0, 7));
    else nbytes = 3'($urandom_range(1, WordBytes));
    send_message(n_words, nbytes, $urandom_range(0, 11) == 0);
  endtask

  // empty message, by flag and by a byte count of zero
  task automatic test_empty_message();
    send_item($urandom, 3'd4, 1'b1, 1'b1);
    send_item({WordW{1'b1}}, 3'd0, 1'b1, 1'b0);
  endtask

  // one-word messages with every nonzero byte count, oversized counts too
  task automatic test_short_last_word();
    for (int nb = 1; nb <= 7; nb++) begin
      send_item(nb[0] ? {WordW{1'b1}} : '0, 3'(nb), 1'b1, 1'b0);
    end
  endtask

  // full last word at slot 15 forces a separate padding block
  task automatic test_full_block_padding();
    for (int i = 0; i < 15; i++) begin
      send_item(i[0] ? {WordW{1'b1}} : '0, 3'(i), 1'b0, i[1]);
    end
    send_item({WordW{1'b1}}, 3'd4, 1'b1, 1'b0);
  endtask

  // random messages, idling switched on and off per message
  task automatic test_random_messages(input int unsigned item_target);
    while (items_taken < item_target) begin
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      send_random_message();
    end
  endtask

  // sender stops until the digest is fully out, then goes on
  task automatic test_pause_until_digested();
    send_message($urandom_range(13, 16), 3'($urandom_range(1, WordBytes)), 1'b0);
    wait_for_digests();
    send_message($urandom_range(1, 4), 3'($urandom_range(1, WordBytes)), 1'b0);
  endtask

  // back-to-back messages with no idling on either side
  task automatic test_back_to_back();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_message(14, 3'd3, 1'b0);
    send_message(1, 3'd4, 1'b0);
    send_message(9, 3'd2, 1'b0);
  endtask

  initial begin
    hash_reset();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_empty_message();
    test_short_last_word();
    test_full_block_padding();
    test_random_messages(RandomItems / 2);
    test_pause_until_digested();
    test_random_messages(RandomItems);
    test_back_to_back();

    wait_for_digests();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
